### hw/rtl/mcq_pkg.sv
// Shared constants, types and helpers for the min-conflicts queens step block.
`default_nettype none
package mcq_pkg;

    localparam int MAX_SIZE = 64;
    localparam int COL_W    = 6;
    localparam int ROW_W    = 6;
    localparam int SIZE_W   = 7;
    localparam int CNT_W    = 7;
    localparam int TRY_W    = 8;
    localparam int PICK_W   = 16;
    localparam int STEP_W   = $clog2(MAX_SIZE);
    localparam int DIV_CW   = $clog2(PICK_W);
    localparam int ADDR_W   = 3;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd8;
    localparam logic [SIZE_W-1:0] SIZE_MIN   = 7'd4;
    localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_SIZE);
    localparam logic [TRY_W-1:0]  TRY_SAT    = {TRY_W{1'b1}};

    // register index of board_size (byte address 4*index)
    localparam logic REG_BOARD_SIZE = 1'b0;

    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_SWAP = 2'd1;
    localparam logic [1:0] FUNC_MOVE = 2'd2;
    localparam logic [1:0] FUNC_READ = 2'd3;

    localparam logic [1:0] REM_SWAP = 2'd0;
    localparam logic [1:0] REM_K    = 2'd1;
    localparam logic [1:0] REM_PICK = 2'd2;

    typedef struct packed {
        logic       capture;
        logic       mem_load;
        logic       rd_issue;
        logic       rd_take;
        logic       rem_start;
        logic [1:0] rem_sel;
        logic       sw_read;
        logic       sw_w1;
        logic       sw_w2;
        logic       scan_init;
        logic       col_start;
        logic       sweep_step;
        logic       sweep_lane;
        logic       col_end;
        logic       find_init;
        logic       find_step;
        logic       lane_init;
        logic       min_init;
        logic       min_step;
        logic       pick_init;
        logic       pick_step;
        logic       move_write;
        logic       out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       col_ok;
        logic       rem_busy;
        logic       sweep_last;
        logic       scan_last;
        logic       pass_last;
        logic       move_ok;
    } dp_sts_t;

    function automatic logic [ROW_W-1:0] absdiff(input logic [ROW_W-1:0] a,
                                                 input logic [ROW_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage
`default_nettype wire

### hw/rtl/mcq_if.sv
// Request and result channel interfaces.
`default_nettype none
interface mcq_in_if;
    import mcq_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        func;
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  row_value;
    logic [PICK_W-1:0] pick_a;
    logic [PICK_W-1:0] pick_b;
    modport source (output valid, func, column, row_value, pick_a, pick_b, input ready);
    modport sink   (input valid, func, column, row_value, pick_a, pick_b, output ready);
endinterface

interface mcq_out_if;
    import mcq_pkg::*;
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] conflicted_count;
    logic             solved;
    logic             exhausted;
    logic [ROW_W-1:0] read_row;
    modport source (output valid, conflicted_count, solved, exhausted, read_row,
                    input ready);
    modport sink   (input valid, conflicted_count, solved, exhausted, read_row,
                    output ready);
endinterface
`default_nettype wire

### hw/rtl/mcq_rem.sv
// Restoring remainder unit, one dividend bit per cycle.
`default_nettype none
module mcq_rem (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [mcq_pkg::PICK_W-1:0] dividend,
    input  logic [mcq_pkg::CNT_W-1:0]  divisor,
    output logic                      busy,
    output logic [mcq_pkg::CNT_W-1:0]  rem
);
    import mcq_pkg::*;

    logic              busy_reg, busy_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic [PICK_W-1:0] q_reg, q_next;
    logic [CNT_W-1:0]  d_reg, d_next;
    logic [CNT_W-1:0]  r_reg, r_next;
    logic [CNT_W:0]    trial;

    assign trial = {r_reg, q_reg[PICK_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        r_next    = r_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = dividend;
            d_next    = divisor;
            r_next    = '0;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[PICK_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (trial >= {1'b0, d_reg})
                r_next = CNT_W'(trial - {1'b0, d_reg});
            else
                r_next = trial[CNT_W-1:0];
            if (cnt_reg == DIV_CW'(PICK_W - 1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        d_reg <= d_next;
        r_reg <= r_next;
    end

    assign busy = busy_reg;
    assign rem  = r_reg;

endmodule
`default_nettype wire

### hw/rtl/mcq_dp.sv
// Datapath: board memory, conflict scan, row lanes, selection and result registers.
`default_nettype none
module mcq_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  mcq_pkg::dp_cmd_t           cmd,
    output mcq_pkg::dp_sts_t           sts,
    input  logic [1:0]                 in_func,
    input  logic [mcq_pkg::COL_W-1:0]  in_column,
    input  logic [mcq_pkg::ROW_W-1:0]  in_row_value,
    input  logic [mcq_pkg::PICK_W-1:0] in_pick_a,
    input  logic [mcq_pkg::PICK_W-1:0] in_pick_b,
    input  logic                       cfg_we,
    input  logic [mcq_pkg::SIZE_W-1:0] cfg_data,
    output logic [mcq_pkg::SIZE_W-1:0] size_q,
    output logic [mcq_pkg::CNT_W-1:0]  conflicted_count,
    output logic                       solved,
    output logic                       exhausted,
    output logic [mcq_pkg::ROW_W-1:0]  read_row
);
    import mcq_pkg::*;

    // board memory
    logic [ROW_W-1:0]  rows_mem [MAX_SIZE];
    logic              we;
    logic [COL_W-1:0]  waddr;
    logic [ROW_W-1:0]  wdata;
    logic              re_a, re_b;
    logic [COL_W-1:0]  raddr_a, raddr_b;
    logic [ROW_W-1:0]  rd_a_reg, rd_b_reg;

    // request
    logic [1:0]        func_reg;
    logic [COL_W-1:0]  column_reg;
    logic [ROW_W-1:0]  row_value_reg;
    logic [PICK_W-1:0] pick_a_reg, pick_b_reg;

    // control state
    logic [SIZE_W-1:0] size_reg;
    logic [TRY_W-1:0]  try_reg;

    logic [SIZE_W-1:0] n;
    logic              col_ok;
    logic              exh;

    // scan
    logic [COL_W-1:0]    i_reg;
    logic [SIZE_W-1:0]   j_reg;
    logic                a_vld_reg;
    logic [COL_W-1:0]    a_tag_reg;
    logic                hit_reg;
    logic                col_hit;
    logic                issue;
    logic [CNT_W-1:0]    cnt_reg;
    logic [MAX_SIZE-1:0] flags_reg;
    logic [MAX_SIZE-1:0] walk_reg;

    // move
    logic [CNT_W-1:0]    lanes_reg [MAX_SIZE];
    logic [MAX_SIZE-1:0] lane_hit;
    logic [STEP_W-1:0]   step_reg;
    logic                step_in;
    logic [CNT_W-1:0]    k_reg;
    logic                found_reg;
    logic [COL_W-1:0]    mcol_reg;
    logic [CNT_W-1:0]    best_reg;
    logic [CNT_W-1:0]    ties_reg;
    logic [ROW_W-1:0]    newrow_reg;
    logic [ROW_W-1:0]    rd_reg;

    // remainder unit
    logic [PICK_W-1:0] div_a;
    logic [CNT_W-1:0]  div_d;
    logic              rem_busy;
    logic [CNT_W-1:0]  rem_val;

    always_comb
    begin
        if (size_reg < SIZE_MIN)
            n = SIZE_MIN;
        else if (size_reg > SIZE_MAX)
            n = SIZE_MAX;
        else
            n = size_reg;
    end

    assign col_ok  = {1'b0, column_reg} < n;
    assign exh     = try_reg >= {n, 1'b0};
    assign issue   = cmd.sweep_step && (j_reg < n);
    assign step_in = {1'b0, step_reg} < n;

    assign col_hit = a_vld_reg && (a_tag_reg != i_reg)
                     && ((rd_a_reg == rd_b_reg)
                         || (absdiff(a_tag_reg, i_reg) == absdiff(rd_a_reg, rd_b_reg)));

    always_comb
    begin
        for (int r = 0; r < MAX_SIZE; r++)
        begin
            lane_hit[r] = a_vld_reg && (a_tag_reg != mcol_reg)
                          && ((rd_a_reg == ROW_W'(r))
                              || (absdiff(a_tag_reg, mcol_reg)
                                  == absdiff(rd_a_reg, ROW_W'(r))));
        end
    end

    // memory port selection
    always_comb
    begin
        we      = 1'b0;
        waddr   = column_reg;
        wdata   = row_value_reg;
        re_a    = 1'b0;
        raddr_a = column_reg;
        re_b    = 1'b0;
        raddr_b = i_reg;
        if (cmd.mem_load)
            we = 1'b1;
        else if (cmd.sw_w1)
        begin
            we    = 1'b1;
            wdata = rd_b_reg;
        end
        else if (cmd.sw_w2)
        begin
            we    = 1'b1;
            waddr = rem_val[COL_W-1:0];
            wdata = rd_a_reg;
        end
        else if (cmd.move_write)
        begin
            we    = 1'b1;
            waddr = mcol_reg;
            wdata = newrow_reg;
        end
        if (cmd.rd_issue || cmd.sw_read)
            re_a = 1'b1;
        else if (issue)
        begin
            re_a    = 1'b1;
            raddr_a = j_reg[COL_W-1:0];
        end
        if (cmd.sw_read)
        begin
            re_b    = 1'b1;
            raddr_b = rem_val[COL_W-1:0];
        end
        else if (cmd.col_start)
            re_b = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (we)
            rows_mem[waddr] <= wdata;
        if (re_a)
            rd_a_reg <= rows_mem[raddr_a];
        if (re_b)
            rd_b_reg <= rows_mem[raddr_b];
    end

    always_comb
    begin
        unique case (cmd.rem_sel)
            REM_SWAP:
            begin
                div_a = pick_a_reg;
                div_d = n;
            end
            REM_K:
            begin
                div_a = pick_a_reg;
                div_d = cnt_reg;
            end
            REM_PICK:
            begin
                div_a = pick_b_reg;
                div_d = ties_reg;
            end
            default:
            begin
                div_a = pick_b_reg;
                div_d = ties_reg;
            end
        endcase
    end

    mcq_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.rem_start),
        .dividend (div_a),
        .divisor  (div_d),
        .busy     (rem_busy),
        .rem      (rem_val)
    );

    // control state: board size and try counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
            try_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
                size_reg <= cfg_data;
            if (cmd.sw_w2)
                try_reg <= '0;
            else if (cmd.move_write && (try_reg != TRY_SAT))
                try_reg <= try_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else
            a_vld_reg <= issue;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg      <= in_func;
            column_reg    <= in_column;
            row_value_reg <= in_row_value;
            pick_a_reg    <= in_pick_a;
            pick_b_reg    <= in_pick_b;
            rd_reg        <= '0;
        end
        else if (cmd.rd_take && col_ok)
            rd_reg <= rd_a_reg;

        a_tag_reg <= j_reg[COL_W-1:0];

        // conflict scan over columns
        if (cmd.scan_init)
        begin
            i_reg   <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.col_end)
        begin
            i_reg            <= i_reg + 1'b1;
            cnt_reg          <= cnt_reg + CNT_W'(hit_reg);
            flags_reg[i_reg] <= hit_reg;
        end

        if (cmd.col_start || cmd.lane_init)
            j_reg <= '0;
        else if (issue)
            j_reg <= j_reg + 1'b1;

        if (cmd.col_start)
            hit_reg <= 1'b0;
        else if (cmd.sweep_step && !cmd.sweep_lane && col_hit)
            hit_reg <= 1'b1;

        // shared pass counter
        if (cmd.find_init || cmd.min_init || cmd.pick_init)
            step_reg <= '0;
        else if (cmd.find_step || cmd.min_step || cmd.pick_step)
            step_reg <= step_reg + 1'b1;

        // k-th conflicted column (find) and k-th tied row (pick)
        if (cmd.find_init)
        begin
            walk_reg  <= flags_reg;
            k_reg     <= rem_val;
            found_reg <= 1'b0;
        end
        else if (cmd.find_step)
        begin
            walk_reg <= {1'b0, walk_reg[MAX_SIZE-1:1]};
            if (step_in && walk_reg[0] && !found_reg)
            begin
                if (k_reg == '0)
                begin
                    mcol_reg  <= step_reg;
                    found_reg <= 1'b1;
                end
                else
                    k_reg <= k_reg - 1'b1;
            end
        end
        else if (cmd.pick_init)
        begin
            k_reg     <= rem_val;
            found_reg <= 1'b0;
        end
        else if (cmd.pick_step)
        begin
            if (step_in && (lanes_reg[0] == best_reg) && !found_reg)
            begin
                if (k_reg == '0)
                begin
                    newrow_reg <= step_reg;
                    found_reg  <= 1'b1;
                end
                else
                    k_reg <= k_reg - 1'b1;
            end
        end

        // minimum and tie count over candidate rows
        if (cmd.min_init)
        begin
            best_reg <= {CNT_W{1'b1}};
            ties_reg <= '0;
        end
        else if (cmd.min_step && step_in)
        begin
            if (lanes_reg[0] < best_reg)
            begin
                best_reg <= lanes_reg[0];
                ties_reg <= CNT_W'(1);
            end
            else if (lanes_reg[0] == best_reg)
                ties_reg <= ties_reg + 1'b1;
        end

        // one lane per candidate row; passes rotate them past lane 0
        for (int r = 0; r < MAX_SIZE; r++)
        begin
            if (cmd.lane_init)
                lanes_reg[r] <= '0;
            else if (cmd.sweep_step && cmd.sweep_lane && lane_hit[r])
                lanes_reg[r] <= lanes_reg[r] + 1'b1;
            else if (cmd.min_step || cmd.pick_step)
                lanes_reg[r] <= lanes_reg[(r + 1) % MAX_SIZE];
        end

        if (cmd.out_load)
        begin
            conflicted_count <= cnt_reg;
            solved           <= (cnt_reg == '0);
            exhausted        <= exh;
            read_row         <= rd_reg;
        end
    end

    assign sts.func       = func_reg;
    assign sts.col_ok     = col_ok;
    assign sts.rem_busy   = rem_busy;
    assign sts.sweep_last = a_vld_reg && ({1'b0, a_tag_reg} == (n - 1'b1));
    assign sts.scan_last  = ({1'b0, i_reg} == (n - 1'b1));
    assign sts.pass_last  = (step_reg == {STEP_W{1'b1}});
    assign sts.move_ok    = (cnt_reg != '0) && !exh;
    assign size_q         = size_reg;

endmodule
`default_nettype wire

### hw/rtl/mcq_ctrl.sv
// Controller state machine sequencing each request through the datapath.
`default_nettype none
module mcq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  mcq_pkg::dp_sts_t sts,
    output mcq_pkg::dp_cmd_t cmd
);
    import mcq_pkg::*;

    localparam logic [4:0] S_IDLE       = 5'd0;
    localparam logic [4:0] S_DISPATCH   = 5'd1;
    localparam logic [4:0] S_LOAD       = 5'd2;
    localparam logic [4:0] S_RD         = 5'd3;
    localparam logic [4:0] S_RD2        = 5'd4;
    localparam logic [4:0] S_SW_DIV     = 5'd5;
    localparam logic [4:0] S_SW_WAIT    = 5'd6;
    localparam logic [4:0] S_SW_RD      = 5'd7;
    localparam logic [4:0] S_SW_W1      = 5'd8;
    localparam logic [4:0] S_SW_W2      = 5'd9;
    localparam logic [4:0] S_SCAN_INIT  = 5'd10;
    localparam logic [4:0] S_COL_START  = 5'd11;
    localparam logic [4:0] S_COL_SWEEP  = 5'd12;
    localparam logic [4:0] S_COL_END    = 5'd13;
    localparam logic [4:0] S_MV_CHECK   = 5'd14;
    localparam logic [4:0] S_K_WAIT     = 5'd15;
    localparam logic [4:0] S_FIND       = 5'd16;
    localparam logic [4:0] S_LANE_START = 5'd17;
    localparam logic [4:0] S_LANE_SWEEP = 5'd18;
    localparam logic [4:0] S_MIN_INIT   = 5'd19;
    localparam logic [4:0] S_MIN        = 5'd20;
    localparam logic [4:0] S_PICK_DIV   = 5'd21;
    localparam logic [4:0] S_PICK_WAIT  = 5'd22;
    localparam logic [4:0] S_PICK       = 5'd23;
    localparam logic [4:0] S_MV_WRITE   = 5'd24;
    localparam logic [4:0] S_DONE       = 5'd25;

    logic [4:0] state_reg, state_next;
    logic       moved_reg, moved_next;
    logic       ovalid_reg, ovalid_next;

    always_comb
    begin
        state_next  = state_reg;
        moved_next  = moved_reg;
        ovalid_next = ovalid_reg;
        cmd         = '0;
        cmd.rem_sel = REM_SWAP;
        if (ovalid_reg && out_ready)
            ovalid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    moved_next  = 1'b0;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (sts.func)
                    FUNC_LOAD: state_next = S_LOAD;
                    FUNC_READ: state_next = S_RD;
                    FUNC_SWAP: state_next = sts.col_ok ? S_SW_DIV : S_SCAN_INIT;
                    default:   state_next = S_SCAN_INIT;
                endcase
            end
            S_LOAD:
            begin
                cmd.mem_load = sts.col_ok;
                state_next   = S_SCAN_INIT;
            end
            S_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_RD2;
            end
            S_RD2:
            begin
                cmd.rd_take = 1'b1;
                state_next  = S_SCAN_INIT;
            end
            S_SW_DIV:
            begin
                cmd.rem_start = 1'b1;
                cmd.rem_sel   = REM_SWAP;
                state_next    = S_SW_WAIT;
            end
            S_SW_WAIT:
            begin
                if (!sts.rem_busy)
                    state_next = S_SW_RD;
            end
            S_SW_RD:
            begin
                cmd.sw_read = 1'b1;
                state_next  = S_SW_W1;
            end
            S_SW_W1:
            begin
                cmd.sw_w1  = 1'b1;
                state_next = S_SW_W2;
            end
            S_SW_W2:
            begin
                cmd.sw_w2  = 1'b1;
                state_next = S_SCAN_INIT;
            end
            S_SCAN_INIT:
            begin
                cmd.scan_init = 1'b1;
                state_next    = S_COL_START;
            end
            S_COL_START:
            begin
                cmd.col_start = 1'b1;
                state_next    = S_COL_SWEEP;
            end
            S_COL_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (sts.sweep_last)
                    state_next = S_COL_END;
            end
            S_COL_END:
            begin
                cmd.col_end = 1'b1;
                if (!sts.scan_last)
                    state_next = S_COL_START;
                else if ((sts.func == FUNC_MOVE) && !moved_reg)
                    state_next = S_MV_CHECK;
                else
                    state_next = S_DONE;
            end
            S_MV_CHECK:
            begin
                if (sts.move_ok)
                begin
                    cmd.rem_start = 1'b1;
                    cmd.rem_sel   = REM_K;
                    state_next    = S_K_WAIT;
                end
                else
                    state_next = S_DONE;
            end
            S_K_WAIT:
            begin
                if (!sts.rem_busy)
                begin
                    cmd.find_init = 1'b1;
                    state_next    = S_FIND;
                end
            end
            S_FIND:
            begin
                cmd.find_step = 1'b1;
                if (sts.pass_last)
                    state_next = S_LANE_START;
            end
            S_LANE_START:
            begin
                cmd.lane_init = 1'b1;
                state_next    = S_LANE_SWEEP;
            end
            S_LANE_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                cmd.sweep_lane = 1'b1;
                if (sts.sweep_last)
                    state_next = S_MIN_INIT;
            end
            S_MIN_INIT:
            begin
                cmd.min_init = 1'b1;
                state_next   = S_MIN;
            end
            S_MIN:
            begin
                cmd.min_step = 1'b1;
                if (sts.pass_last)
                    state_next = S_PICK_DIV;
            end
            S_PICK_DIV:
            begin
                cmd.rem_start = 1'b1;
                cmd.rem_sel   = REM_PICK;
                state_next    = S_PICK_WAIT;
            end
            S_PICK_WAIT:
            begin
                if (!sts.rem_busy)
                begin
                    cmd.pick_init = 1'b1;
                    state_next    = S_PICK;
                end
            end
            S_PICK:
            begin
                cmd.pick_step = 1'b1;
                if (sts.pass_last)
                    state_next = S_MV_WRITE;
            end
            S_MV_WRITE:
            begin
                cmd.move_write = 1'b1;
                moved_next     = 1'b1;
                state_next     = S_SCAN_INIT;
            end
            S_DONE:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    ovalid_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            moved_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            moved_reg  <= moved_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ovalid_reg;

endmodule
`default_nettype wire

### hw/rtl/min_conflicts_queens_step.sv
// Top level: min-conflicts queens step engine with APB configuration.
// Usage:
//   in_ch carries one request (func, column, row_value, pick_a, pick_b); it is
//   taken when valid and ready are both high. out_ch returns exactly one result
//   per request (conflicted_count, solved, exhausted, read_row).
//   board_size is written over APB at byte address 0; reads return it.
// Sequence, with n the board size in use (4..64):
//   every request ends with a conflict scan: for each column, one read of
//   the outer queen, then all n columns streamed through memory port A.
//   A swap first runs the remainder unit, then a read and two writes on the
//   single write port.
//   A move adds two remainders, a walk of the conflict flags, a sweep that
//   fills one attack counter per candidate row, two rotations of those
//   counters (one for the minimum and tie count, one for the tie pick) and
//   then a second scan.
//   One request is in flight at a time; ready is high only between requests.
// Reset: board_size returns to 8 and the try counter to zero; board contents
//   are undefined until loaded. No clearing pass is needed.
// Stalls: the result waits in an output register; the next request can be
//   taken meanwhile, and its result is held back until the first is taken.
`default_nettype none
module min_conflicts_queens_step (
    input  logic                        clk,
    input  logic                        rst_n,
    mcq_in_if.sink                      in_ch,
    mcq_out_if.source                   out_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mcq_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import mcq_pkg::*;

    dp_cmd_t           cmd;
    dp_sts_t           sts;
    logic              cfg_we;
    logic [SIZE_W-1:0] size_q;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_BOARD_SIZE);
    assign prdata = (paddr[ADDR_W-1] == REG_BOARD_SIZE) ? {{(32 - SIZE_W){1'b0}}, size_q}
                                                        : 32'd0;

    mcq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    mcq_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .in_func          (in_ch.func),
        .in_column        (in_ch.column),
        .in_row_value     (in_ch.row_value),
        .in_pick_a        (in_ch.pick_a),
        .in_pick_b        (in_ch.pick_b),
        .cfg_we           (cfg_we),
        .cfg_data         (pwdata[SIZE_W-1:0]),
        .size_q           (size_q),
        .conflicted_count (out_ch.conflicted_count),
        .solved           (out_ch.solved),
        .exhausted        (out_ch.exhausted),
        .read_row         (out_ch.read_row)
    );

endmodule
`default_nettype wire

### hw/rtl/mcq_check.sv
// Port-level checker for the queens step block, bound to the top level.
`default_nettype none
module mcq_check (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [mcq_pkg::CNT_W-1:0] conflicted_count,
    input logic                      solved
);
    import mcq_pkg::*;

    // one request at a time: busy right after taking one
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request taken while previous still in progress");

    a_solved_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (solved == (conflicted_count == '0)))
        else $error("solved flag disagrees with conflicted count");

    // a lone queen cannot be attacked, and no more than MAX_SIZE columns can conflict
    a_count_not_one: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((conflicted_count != CNT_W'(1))
                       && (conflicted_count <= CNT_W'(MAX_SIZE))))
        else $error("impossible conflicted count");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(conflicted_count)))
        else $error("result dropped or changed while stalled");

endmodule

bind min_conflicts_queens_step mcq_check u_mcq_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .conflicted_count (out_ch.conflicted_count),
    .solved           (out_ch.solved)
);
`default_nettype wire

### test/testbench.sv
// Testbench for min_conflicts_queens_step: directed and random requests against a predictor.
`timescale 1ns / 100ps
module testbench;
    import mcq_pkg::*;

    typedef struct {
        logic [CNT_W-1:0] conflicted;
        logic             solved;
        logic             exhausted;
        logic [ROW_W-1:0] read_row;
        bit               board_known;
    } queens_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel, penable, pwrite, pready;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;

    mcq_in_if  in_ch ();
    mcq_out_if out_ch ();

    min_conflicts_queens_step u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    // predictor state
    logic [ROW_W-1:0] board [MAX_SIZE];
    bit               written [MAX_SIZE];
    int               tries;
    int               size_reg;
    queens_result_t   expected_q [$];
    int               errors;
    int               tx_idle;
    int               rx_idle;

    function automatic int size_now();
        if (size_reg < 4)
            return 4;
        if (size_reg > MAX_SIZE)
            return MAX_SIZE;
        return size_reg;
    endfunction

    function automatic int gap(int a, int b);
        return (a > b) ? a - b : b - a;
    endfunction

    // queens that would attack a queen at (row, col)
    function automatic int attackers(int row, int col, int n);
        int c;
        c = 0;
        for (int i = 0; i < n; i++)
            if (i != col && (board[i] == row || gap(i, col) == gap(board[i], row)))
                c++;
        return c;
    endfunction

    function automatic int conflicted_cols(int n);
        int c;
        c = 0;
        for (int i = 0; i < n; i++)
            if (attackers(board[i], i, n) != 0)
                c++;
        return c;
    endfunction

    function automatic void min_conflict_move(int pa, int pb, int n);
        int cnt, k, col, best, ties, pick, r;
        int hits [MAX_SIZE];
        cnt = conflicted_cols(n);
        if (cnt == 0 || tries >= 2 * n)
            return;
        k = pa % cnt;
        col = 0;
        for (int i = 0; i < n; i++)
            if (attackers(board[i], i, n) != 0) begin
                if (k == 0)
                begin
                    col = i;
                    break;
                end
                k--;
            end
        best = 1 << 20;
        for (int j = 0; j < n; j++)
        begin
            hits[j] = attackers(j, col, n);
            if (hits[j] < best)
                best = hits[j];
        end
        ties = 0;
        for (int j = 0; j < n; j++)
            if (hits[j] == best)
                ties++;
        pick = pb % ties;
        for (r = 0; r < n; r++)
            if (hits[r] == best) begin
                if (pick == 0)
                    break;
                pick--;
            end
        board[col] = ROW_W'(r);
        if (tries < 255)
            tries++;
    endfunction

    function automatic void predict_request(logic [1:0] f, int col, int rowv, int pa, int pb);
        int n, rd, j, cnt;
        logic [ROW_W-1:0] t;
        queens_result_t res;
        n = size_now();
        rd = 0;
        case (f)
            FUNC_LOAD:
                if (col < n)
                begin
                    board[col] = ROW_W'(rowv);
                    written[col] = 1'b1;
                end
            FUNC_SWAP:
                if (col < n)
                begin
                    j = pa % n;
                    t = board[col];
                    board[col] = board[j];
                    board[j] = t;
                    tries = 0;
                end
            FUNC_MOVE:
                min_conflict_move(pa, pb, n);
            default:
                if (col < n)
                    rd = board[col];
        endcase
        cnt = conflicted_cols(n);
        res.conflicted = CNT_W'(cnt);
        res.solved = (cnt == 0);
        res.exhausted = (tries >= 2 * n);
        res.read_row = ROW_W'(rd);
        res.board_known = 1'b1;
        for (int i = 0; i < n; i++)
            if (!written[i])
                res.board_known = 1'b0;
        expected_q.insert(expected_q.size(), res);
    endfunction

    task automatic send_request(logic [1:0] f, int col, int rowv, int pa, int pb);
        bit taken;
        if (tx_idle > 0 && $urandom_range(99) < tx_idle)
        begin
            in_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < tx_idle);
        end
        in_ch.valid     <= 1'b1;
        in_ch.func      <= f;
        in_ch.column    <= COL_W'(col);
        in_ch.row_value <= ROW_W'(rowv);
        in_ch.pick_a    <= PICK_W'(pa);
        in_ch.pick_b    <= PICK_W'(pb);
        do
        begin
            @(negedge clk);
            taken = in_ch.ready;
            @(posedge clk);
        end
        while (!taken);
        predict_request(f, col, rowv, pa, pb);
    endtask

    // wait until every result is back
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_board_size(int v);
        drain();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_W'(4 * REG_BOARD_SIZE);
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        size_reg = v & 8'h7f;
        @(posedge clk);
    endtask

    task automatic load_board(int n);
        for (int c = 0; c < n; c++)
            send_request(FUNC_LOAD, c,
                         ($urandom_range(9) < 8) ? $urandom_range(n - 1) : $urandom_range(63),
                         $urandom_range(65535), $urandom_range(65535));
    endtask

    task automatic test_fill_board();
        set_board_size(64);
        load_board(64);
    endtask

    task automatic test_directed();
        set_board_size(8);
        for (int c = 0; c < 8; c++)
            send_request(FUNC_LOAD, c, 0, 0, 0);
        send_request(FUNC_READ, 0, 0, 0, 0);
        send_request(FUNC_READ, 63, 0, 0, 0);        // column beyond size
        send_request(FUNC_LOAD, 63, 5, 0, 0);
        send_request(FUNC_LOAD, 2, 63, 0, 0);        // row beyond size
        send_request(FUNC_SWAP, 40, 0, 16'hffff, 0);
        send_request(FUNC_SWAP, 1, 0, 16'hffff, 0);
        for (int i = 0; i < 6; i++)
            send_request(FUNC_MOVE, 0, 0, (i & 1) ? 16'hffff : 0, (i & 2) ? 16'hffff : 0);
        send_request(FUNC_READ, 2, 0, 0, 0);
        set_board_size(4);
        send_request(FUNC_LOAD, 0, 1, 0, 0);
        send_request(FUNC_LOAD, 1, 3, 0, 0);
        send_request(FUNC_LOAD, 2, 0, 0, 0);
        send_request(FUNC_LOAD, 3, 2, 0, 0);
        send_request(FUNC_MOVE, 0, 0, 16'hffff, 16'hffff);  // already solved
        send_request(FUNC_READ, 3, 0, 0, 0);
        set_board_size(0);
        send_request(FUNC_MOVE, 0, 0, 7, 3);
        set_board_size(127);
        send_request(FUNC_READ, 63, 0, 0, 0);
        send_request(FUNC_MOVE, 0, 0, 16'h1234, 16'h5678);
    endtask

    task automatic test_random(int tx, int rx, int count);
        int sent, n, burst, col, rowv, sel;
        logic [1:0] f;
        tx_idle = tx;
        rx_idle = rx;
        sent = 0;
        while (sent < count)
        begin
            sel = $urandom_range(99);
            if (sel < 2)
                set_board_size(64);
            else if (sel < 5)
                set_board_size($urandom_range(3));
            else if (sel < 15)
                set_board_size($urandom_range(24, 13));
            else
                set_board_size($urandom_range(12, 4));
            n = size_now();
            burst = (n == 64) ? 6 : $urandom_range(60, 20);
            if (n < 64)
            begin
                load_board(n);
                sent += n;
            end
            for (int i = 0; i < burst; i++)
            begin
                sel = $urandom_range(99);
                f = (sel < 45) ? FUNC_MOVE : (sel < 58) ? FUNC_SWAP :
                    (sel < 75) ? FUNC_LOAD : FUNC_READ;
                col = ($urandom_range(9) < 9) ? $urandom_range(n - 1) : $urandom_range(63);
                rowv = ($urandom_range(9) < 8) ? $urandom_range(n - 1) : $urandom_range(63);
                send_request(f, col, rowv, $urandom_range(65535), $urandom_range(65535));
            end
            sent += burst;
        end
        drain();
    endtask

    always @(posedge clk or negedge rst_n)
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= rx_idle);

    // results are stable at the falling edge before they are taken
    always @(negedge clk)
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            queens_result_t e;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result count=%0d", $time, out_ch.conflicted_count);
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (e.board_known && out_ch.conflicted_count !== e.conflicted)
                begin
                    $display("%0t: conflicted_count expected %0d actual %0d",
                             $time, e.conflicted, out_ch.conflicted_count);
                    errors++;
                end
                if (e.board_known && out_ch.solved !== e.solved)
                begin
                    $display("%0t: solved expected %0d actual %0d",
                             $time, e.solved, out_ch.solved);
                    errors++;
                end
                if (out_ch.exhausted !== e.exhausted)
                begin
                    $display("%0t: exhausted expected %0d actual %0d",
                             $time, e.exhausted, out_ch.exhausted);
                    errors++;
                end
                if (out_ch.read_row !== e.read_row)
                begin
                    $display("%0t: read_row expected %0d actual %0d",
                             $time, e.read_row, out_ch.read_row);
                    errors++;
                end
            end
        end

    initial
    begin
        #500_000_000;
        $display("min_conflicts_queens_step test failed");
        $finish;
    end

    initial
    begin
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.func = FUNC_READ;
        in_ch.column = '0;
        in_ch.row_value = '0;
        in_ch.pick_a = '0;
        in_ch.pick_b = '0;
        errors = 0;
        tries = 0;
        size_reg = 8;
        tx_idle = 26;
        rx_idle = 64;
        for (int i = 0; i < MAX_SIZE; i++)
        begin
            board[i] = '0;
            written[i] = 1'b0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_fill_board();
        test_directed();
        test_random(26, 64, 600);
        test_random(64, 26, 600);
        test_random(0, 0, 600);
        drain();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("min_conflicts_queens_step test passed");
        else
            $display("min_conflicts_queens_step test failed");
        $finish;
    end
endmodule

### sim.f
hw/rtl/mcq_pkg.sv
hw/rtl/mcq_if.sv
hw/rtl/mcq_rem.sv
hw/rtl/mcq_dp.sv
hw/rtl/mcq_ctrl.sv
hw/rtl/min_conflicts_queens_step.sv
hw/rtl/mcq_check.sv
test/testbench.sv
